FILE: sv/clr_pkg.sv
// Shared types and constants for the clamped line rasterizer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package clr_pkg;

  // Field widths fixed by the command and pixel formats.
  localparam int IN_W     = 10;
  localparam int COORD_W  = 6;
  localparam int COLOUR_W = 16;

  // Doubled deltas reach 2 * 63, and the error term stays within +/- 2 * 126.
  localparam int DELTA2_W = COORD_W + 1;
  localparam int ERR_W    = DELTA2_W + 3;

  // Default display size.
  localparam int DEF_COLUMNS = 64;
  localparam int DEF_ROWS    = 64;

  // Depth of the queue between setup and walker.
  localparam int QUEUE_DEPTH = 2;

  // One line, prepared for the walker: start point, step signs, major axis,
  // doubled deltas, initial error and the number of steps after the first pixel.
  typedef struct packed {
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic                sx_neg;
    logic                sy_neg;
    logic                x_major;
    logic [DELTA2_W-1:0] dx2;
    logic [DELTA2_W-1:0] dy2;
    logic [ERR_W-1:0]    err;
    logic [COORD_W-1:0]  count;
    logic [COLOUR_W-1:0] colour;
  } clr_cmd_t;

endpackage

`default_nettype wire

FILE: sv/clamped_line_rasterizer_core.sv
// Top level of the clamped line rasterizer: front end, line queue, walker.
// Depends on clr_pkg, clr_front, clr_queue, clr_back and clr_core.
//
// Input channel: a line request (start_x, start_y, end_x, end_y, colour_word)
// is taken at a clock edge with push high and full low. Endpoints are signed
// and clamped to the display on each axis before drawing.
// Output channel: while empty is low, one pixel write is on pixel_x, pixel_y,
// pixel_colour and last_pixel; it is taken at an edge with pop high. Pixels
// come in drawing order, and last_pixel marks the final one of each line.
// Path: a taken request is clamped into a register at the accepting edge,
// then written to the queue, loaded into the walker and written to the
// output register.
// Throughput: the walker emits one pixel per cycle while the receiver keeps
// taking pixels, and loads each line before it walks it. The front end
// prepares the next line meanwhile, and the two-entry queue lets requests
// keep arriving while a long line is walked.
// Reset (rst, synchronous) empties the queue and the output register.
// When the receiver stalls, the pixel holds on the outputs, the walker
// waits, and once queue and clamp register fill, full holds off requests.
`timescale 1ns / 1ps
`default_nettype none

module clamped_line_rasterizer_core #(
  parameter int DISPLAY_COLUMNS = clr_pkg::DEF_COLUMNS,
  parameter int DISPLAY_ROWS    = clr_pkg::DEF_ROWS
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 push,
  output logic                                full,
  input  wire  signed [clr_pkg::IN_W-1:0]     start_x,
  input  wire  signed [clr_pkg::IN_W-1:0]     start_y,
  input  wire  signed [clr_pkg::IN_W-1:0]     end_x,
  input  wire  signed [clr_pkg::IN_W-1:0]     end_y,
  input  wire         [clr_pkg::COLOUR_W-1:0] colour_word,
  output logic                                empty,
  input  wire                                 pop,
  output logic        [clr_pkg::COORD_W-1:0]  pixel_x,
  output logic        [clr_pkg::COORD_W-1:0]  pixel_y,
  output logic        [clr_pkg::COLOUR_W-1:0] pixel_colour,
  output logic                                last_pixel
);
  import clr_pkg::*;

  clr_cmd_t   front_cmd;
  clr_cmd_t   queue_cmd;
  logic       q_push, q_full, q_pop, q_empty;

  // Clamp and set up each request.
  clr_front #(
    .DISPLAY_COLUMNS(DISPLAY_COLUMNS),
    .DISPLAY_ROWS   (DISPLAY_ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .colour_word(colour_word),
    .q_push     (q_push),
    .q_full     (q_full),
    .cmd        (front_cmd)
  );

  // Prepared lines waiting for the walker.
  clr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(front_cmd),
    .full (q_full),
    .pop  (q_pop),
    .rdata(queue_cmd),
    .empty(q_empty)
  );

  // Queue occupancy checks.
  clr_core u_track (
    .clk   (clk),
    .rst   (rst),
    .q_push(q_push),
    .q_pop (q_pop)
  );

  // Walk each line into the pixel output register.
  clr_back #(
    .DISPLAY_COLUMNS(DISPLAY_COLUMNS),
    .DISPLAY_ROWS   (DISPLAY_ROWS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .cmd         (queue_cmd),
    .empty       (empty),
    .pop         (pop),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_colour(pixel_colour),
    .last_pixel  (last_pixel)
  );

endmodule

`default_nettype wire

FILE: sv/clr_front.sv
// Command front end: takes a line request, clamps both endpoints and
// prepares the walker setup. Depends on clr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clr_front #(
  parameter int DISPLAY_COLUMNS = clr_pkg::DEF_COLUMNS,
  parameter int DISPLAY_ROWS    = clr_pkg::DEF_ROWS
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                push,
  output logic                               full,
  input  wire  signed [clr_pkg::IN_W-1:0]    start_x,
  input  wire  signed [clr_pkg::IN_W-1:0]    start_y,
  input  wire  signed [clr_pkg::IN_W-1:0]    end_x,
  input  wire  signed [clr_pkg::IN_W-1:0]    end_y,
  input  wire         [clr_pkg::COLOUR_W-1:0] colour_word,
  output logic                               q_push,
  input  wire                                q_full,
  output clr_pkg::clr_cmd_t                  cmd
);
  import clr_pkg::*;

  localparam logic signed [IN_W-1:0] X_MAX = IN_W'(DISPLAY_COLUMNS - 1);
  localparam logic signed [IN_W-1:0] Y_MAX = IN_W'(DISPLAY_ROWS - 1);

  function automatic logic [COORD_W-1:0] clamp(input logic signed [IN_W-1:0] v,
                                               input logic signed [IN_W-1:0] hi);
    logic [COORD_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > hi) begin
      r = hi[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  logic                cv;
  logic [COORD_W-1:0]  xa, ya, xb, yb;
  logic [COLOUR_W-1:0] colour;
  logic                accept;

  // The clamped request moves on as soon as the queue has room.
  assign q_push = cv && !q_full;
  assign full   = cv && q_full;
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= 1'b0;
    end else if (accept) begin
      cv <= 1'b1;
    end else if (q_push) begin
      cv <= 1'b0;
    end
  end

  // Clamp each endpoint to the display on each axis.
  always_ff @(posedge clk) begin
    if (accept) begin
      xa     <= clamp(start_x, X_MAX);
      ya     <= clamp(start_y, Y_MAX);
      xb     <= clamp(end_x, X_MAX);
      yb     <= clamp(end_y, Y_MAX);
      colour <= colour_word;
    end
  end

  logic               vertical, horizontal, x_major;
  logic               xb_lt, yb_lt;
  logic [COORD_W-1:0] adx, ady;

  // Classify the line and derive the walker setup. Axis-aligned lines are
  // walked from their low end with a zero minor delta.
  always_comb begin
    vertical   = (xa == xb);
    horizontal = !vertical && (ya == yb);
    xb_lt      = (xb < xa);
    yb_lt      = (yb < ya);
    adx        = xb_lt ? (xa - xb) : (xb - xa);
    ady        = yb_lt ? (ya - yb) : (yb - ya);
    x_major    = (adx > ady);

    cmd.x       = (horizontal && xb_lt) ? xb : xa;
    cmd.y       = (vertical && yb_lt) ? yb : ya;
    cmd.sx_neg  = !horizontal && xb_lt;
    cmd.sy_neg  = !vertical && yb_lt;
    cmd.x_major = x_major;
    cmd.dx2     = {adx, 1'b0};
    cmd.dy2     = {ady, 1'b0};
    cmd.err     = x_major ? (ERR_W'({ady, 1'b0}) - ERR_W'(adx))
                          : (ERR_W'({adx, 1'b0}) - ERR_W'(ady));
    cmd.count   = x_major ? adx : ady;
    cmd.colour  = colour;
  end

endmodule

`default_nettype wire

FILE: sv/clr_queue.sv
// Small register queue of prepared lines between setup and walker.
// Depends on clr_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module clr_queue #(
  parameter int DEPTH = clr_pkg::QUEUE_DEPTH
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  clr_pkg::clr_cmd_t  wdata,
  output logic               full,
  input  wire                pop,
  output clr_pkg::clr_cmd_t  rdata,
  output logic               empty
);
  import clr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  clr_cmd_t           entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   fill;
  logic               do_push, do_pop;

  assign full    = (fill == CNT_W'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: sv/clr_back.sv
// Line walker: steps one prepared line a pixel per cycle, while the
// receiver keeps taking pixels, into an output register. Depends on clr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clr_back #(
  parameter int DISPLAY_COLUMNS = clr_pkg::DEF_COLUMNS,
  parameter int DISPLAY_ROWS    = clr_pkg::DEF_ROWS
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            q_empty,
  output logic                           q_pop,
  input  clr_pkg::clr_cmd_t              cmd,
  output logic                           empty,
  input  wire                            pop,
  output logic [clr_pkg::COORD_W-1:0]    pixel_x,
  output logic [clr_pkg::COORD_W-1:0]    pixel_y,
  output logic [clr_pkg::COLOUR_W-1:0]   pixel_colour,
  output logic                           last_pixel
);
  import clr_pkg::*;

  logic                busy;
  logic                out_valid;
  clr_cmd_t            cur;
  logic                advance;
  logic                minor_step;
  logic                x_step, y_step;
  logic [ERR_W-1:0]    err_adj;
  logic [ERR_W-1:0]    err_next;
  logic [COORD_W-1:0]  x_next, y_next;

  assign empty   = !out_valid;
  assign q_pop   = !busy && !q_empty;
  assign advance = busy && (!out_valid || pop);

  // One Bresenham step: the major axis always moves, the minor axis moves
  // when the error term is not negative.
  always_comb begin
    minor_step = !cur.err[ERR_W-1];
    if (cur.x_major) begin
      err_adj  = minor_step ? (cur.err - ERR_W'(cur.dx2)) : cur.err;
      err_next = err_adj + ERR_W'(cur.dy2);
    end else begin
      err_adj  = minor_step ? (cur.err - ERR_W'(cur.dy2)) : cur.err;
      err_next = err_adj + ERR_W'(cur.dx2);
    end
    x_step = cur.x_major || minor_step;
    y_step = !cur.x_major || minor_step;
    x_next = x_step ? (cur.sx_neg ? cur.x - 1'b1 : cur.x + 1'b1) : cur.x;
    y_next = y_step ? (cur.sy_neg ? cur.y - 1'b1 : cur.y + 1'b1) : cur.y;
  end

  // Walker control: load a line when idle, drop busy after its last pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (q_pop) begin
      busy <= 1'b1;
    end else if (advance && (cur.count == '0)) begin
      busy <= 1'b0;
    end
  end

  // Walker datapath.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= cmd;
    end else if (advance) begin
      cur.x     <= x_next;
      cur.y     <= y_next;
      cur.err   <= err_next;
      cur.count <= cur.count - 1'b1;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      pixel_x      <= cur.x;
      pixel_y      <= cur.y;
      pixel_colour <= cur.colour;
      last_pixel   <= (cur.count == '0);
    end
  end

  // A line ends right after its final pixel is written out.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (advance && (cur.count == '0)) |=> !busy)
    else $error("walker still busy after the last pixel");

  // Each emitted pixel before the last takes exactly one step off the count.
  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    (advance && (cur.count != '0)) |=>
      (busy && (cur.count == COORD_W'($past(cur.count) - 1'b1))))
    else $error("step count did not advance by one");

  // While the walker is stalled it stays busy and its step count holds.
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (busy && !advance) |=> (busy && $stable(cur.count)))
    else $error("walker state changed while stalled");

  // Every pixel written into an empty output register lies on the display.
  a_on_display: assert property (@(posedge clk) disable iff (rst)
    (advance && !out_valid) |=> ((int'(pixel_x) < DISPLAY_COLUMNS) &&
                                 (int'(pixel_y) < DISPLAY_ROWS)))
    else $error("pixel outside the display");

endmodule

`default_nettype wire

FILE: sv/clr_core.sv
// Occupancy checker for the queue of prepared lines between setup and walker.
// Depends on clr_pkg for the queue depth.
`timescale 1ns / 1ps
`default_nettype none

module clr_core (
  input  wire clk,
  input  wire rst,
  input  wire q_push,
  input  wire q_pop
);
  import clr_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] in_flight;

  // Number of prepared lines that have entered the queue but not left it.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else if (q_push && !q_pop) begin
      in_flight <= in_flight + 1'b1;
    end else if (q_pop && !q_push) begin
      in_flight <= in_flight - 1'b1;
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    (int'(in_flight) <= QUEUE_DEPTH))
    else $error("more lines in flight than the queue holds");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    (in_flight == '0) |-> !(q_pop && !q_push))
    else $error("line taken from an empty queue");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    (q_push && !q_pop) |=> (in_flight == CNT_W'($past(in_flight) + 1'b1)))
    else $error("push not counted");

endmodule

`default_nettype wire
